@@ rtl/spr_pkg.sv @@
// Package for the stream pattern replace block: widths, register codes,
// payload and burst types, and the length clamp.
// No dependencies.
`timescale 1ns / 1ps

package spr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int CFG_W           = 64;
    localparam int WIN_W           = MAX_PATTERN * BYTE_W;
    localparam int CNT_W           = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W           = $clog2(MAX_PATTERN);
    localparam int REG_IDX_W       = 2;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_BYTES,
        REG_PATTERN_LENGTH,
        REG_REPLACEMENT_BYTES,
        REG_REPLACEMENT_LENGTH
    } reg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_has_byte;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_has_byte;
        logic              out_last;
        logic              pattern_found;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic [CFG_W-1:0] replacement_bytes;
        logic [LEN_W-1:0] replacement_length;
    } cfg_t;

    // One accepted word's worth of output: up to MAX_PATTERN bytes.
    typedef struct packed {
        logic [WIN_W-1:0] data;
        logic [CNT_W-1:0] count;
        logic             last;
        logic             found;
    } burst_t;

    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v > LEN_W'(MAX_PATTERN))
            r = CNT_W'(MAX_PATTERN);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

@@ rtl/stream_pattern_replace_core.sv @@
// A word's first result passes through the burst queue and then the result register to reach
// the result port. Throughput: one word per cycle while each word yields at most one result
// and results are popped as they show; a word that yields several holds the back end, and the
// burst queue of QUEUE_DEPTH entries absorbs that. Reset clears the configuration registers,
// the window count, the found flag, the queue and the result valid flag; no clearing pass.
// Top level: configuration registers, front end, burst queue, back end. Uses spr_pkg.
`timescale 1ns / 1ps

module stream_pattern_replace_core
    import spr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             item,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            result,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   take;
    burst_t burst;
    logic   burst_valid;
    burst_t head;
    logic   head_empty;
    logic   head_take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_PATTERN_BYTES:      cfg_next.pattern_bytes      = wr_data;
                REG_PATTERN_LENGTH:     cfg_next.pattern_length     = wr_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  cfg_next.replacement_bytes  = wr_data;
                REG_REPLACEMENT_LENGTH: cfg_next.replacement_length = wr_data[LEN_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign take = push && !full;

    spr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .take        (take),
        .item        (item),
        .burst       (burst),
        .burst_valid (burst_valid)
    );

    spr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (burst_valid),
        .wr_data (burst),
        .full    (full),
        .rd_en   (head_take),
        .rd_data (head),
        .empty   (head_empty)
    );

    spr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!head_empty),
        .head_take  (head_take),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

@@ rtl/spr_front.sv @@
// Front end: holds the match window, compares it with the pattern and
// turns each accepted word into at most one burst for the queue.
// Depends on spr_pkg.
`timescale 1ns / 1ps

module spr_front
    import spr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     take,
    input  in_item_t item,
    output burst_t   burst,
    output logic     burst_valid
);

    logic [WIN_W-1:0] window_reg;
    logic [WIN_W-1:0] window_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             found_reg;
    logic             found_next;

    logic [CNT_W-1:0] p_len;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] drop;
    logic [CNT_W+2:0] shamt;
    logic [WIN_W-1:0] win_ins;
    logic             match;

    always_comb
    begin
        p_len   = eff_len(cfg.pattern_length);
        r_len   = eff_len(cfg.replacement_length);
        win_ins = window_reg;
        fill    = count_reg;
        if (item.in_has_byte)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                if (count_reg == CNT_W'(i))
                    win_ins[i*BYTE_W +: BYTE_W] = item.in_byte;
            end
            fill = count_reg + 1'b1;
        end

        match = item.in_has_byte && (p_len != '0) && (fill == p_len);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CNT_W'(i) < p_len) &&
                (win_ins[i*BYTE_W +: BYTE_W] != cfg.pattern_bytes[i*BYTE_W +: BYTE_W]))
                match = 1'b0;
        end

        // pass on the oldest bytes until fewer than the pattern length remain
        drop = '0;
        if (item.in_has_byte)
        begin
            if (p_len == '0)
                drop = fill;
            else if (fill >= p_len)
                drop = fill - p_len + 1'b1;
        end
        shamt = {drop, 3'b000};

        burst.data  = match ? cfg.replacement_bytes[WIN_W-1:0] : win_ins;
        burst.count = match ? r_len : (item.in_last ? fill : drop);
        burst.last  = item.in_last;
        burst.found = found_reg | match;
        burst_valid = take && ((burst.count != '0) || item.in_last);

        window_next = window_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        if (take)
        begin
            window_next = win_ins >> shamt;
            count_next  = (match || item.in_last) ? '0 : (fill - drop);
            found_next  = item.in_last ? 1'b0 : (found_reg | match);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

endmodule

@@ rtl/spr_fifo.sv @@
// Burst queue between the front end and the back end.
// Depends on spr_pkg.
`timescale 1ns / 1ps

module spr_fifo
    import spr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  burst_t wr_data,
    output logic   full,
    input  logic   rd_en,
    output burst_t rd_data,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W = $clog2(DEPTH + 1);

    burst_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;

    assign full    = (num_reg == NUM_W'(DEPTH));
    assign empty   = (num_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        num_next    = num_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            num_next = num_reg + 1'b1;
        else if (!wr_en && rd_en)
            num_next = num_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            num_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            num_reg    <= num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ rtl/spr_back.sv @@
// Back end: walks each queued burst into the result register one byte per cycle while that
// register is empty or being popped. Depends on spr_pkg.
`timescale 1ns / 1ps

module spr_back
    import spr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  burst_t    head,
    input  logic      head_valid,
    output logic      head_take,
    output out_item_t result,
    output logic      empty,
    input  logic      pop
);

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    out_item_t        out_reg;
    out_item_t        out_next;

    logic [CNT_W-1:0] n_items;
    logic             advance;
    logic             final_one;

    always_comb
    begin
        n_items   = (head.count == '0) ? CNT_W'(1) : head.count;
        advance   = head_valid && (!valid_reg || pop);
        final_one = (idx_reg == n_items - 1'b1);
        head_take = advance && final_one;

        out_next.out_byte      = (head.count == '0) ? '0 :
                                 head.data[idx_reg[IDX_W-1:0]*BYTE_W +: BYTE_W];
        out_next.out_has_byte  = (head.count != '0);
        out_next.out_last      = final_one && head.last;
        out_next.pattern_found = final_one && head.last && head.found;

        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            idx_next   = final_one ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (pop)
            valid_next = 1'b0;
    end

    assign result = out_reg;
    assign empty  = !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

endmodule

@@ rtl/spr_checker.sv @@
// Port-level checks on the result side of the stream pattern replace block,
// bound to stream_pattern_replace_core. Uses spr_pkg.
`timescale 1ns / 1ps

module spr_port_checker
    import spr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while waiting");

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.out_has_byte) |-> result.out_last)
        else $error("marker word without end of string");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.out_has_byte) |-> (result.out_byte == '0))
        else $error("marker word carries a byte");

    a_found_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.pattern_found) |-> result.out_last)
        else $error("found flag away from end of string");

endmodule

bind stream_pattern_replace_core spr_port_checker u_spr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
